FILE: design/bir_pkg.sv
`default_nettype none
package bir_pkg;

    // frame store geometry and fraction precision
    localparam int MAX_SRC_WIDTH  = 128;
    localparam int MAX_SRC_HEIGHT = 128;
    localparam int FRAC_BITS      = 11;

    // item field widths
    localparam int COORD_W = 12;
    localparam int CH_W    = 8;
    localparam int CH_N    = 3;
    localparam int DIM_CFG_W   = 8;
    localparam int SCALE_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // index and bank addressing
    localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DIM_W   = IDX_W + 1;
    localparam int BCOL_W  = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int BROW_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
    localparam int BADDR_W = BCOL_W + BROW_W;
    localparam int BANK_DEPTH = 1 << BADDR_W;
    localparam int LANES   = 4;

    // position arithmetic: u = (2d+1)*scale + 2^16, in units of 2^-17
    localparam int POS_SHIFT = 17;
    localparam int PROD_W    = COORD_W + 1 + SCALE_W;
    localparam int U_W       = PROD_W + 1;
    localparam int WHOLE_W   = U_W - POS_SHIFT;
    localparam logic [U_W-1:0] POS_HALF = U_W'(1) << (POS_SHIFT - 1);

    // weights and products
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int WPROD_W = 2 * FRAC_BITS + 1;
    localparam int PRODC_W = WPROD_W + CH_W;
    localparam int ACC_W   = PRODC_W + 2;
    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1) << FRAC_BITS;

    typedef logic [CH_N-1:0][CH_W-1:0]    t_pix;
    typedef logic [WGT_W-1:0]             t_weight;
    typedef logic [CH_N-1:0][PRODC_W-1:0] t_lane_prod;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_REQUEST = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_SCALE_X    = 3'd2,
        CFG_SCALE_Y    = 3'd3
    } t_cfg_idx;

    // result of mapping one axis
    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [FRAC_BITS-1:0] frac;
    } t_axis_map;

    // per-bank access and weight selection
    typedef struct packed {
        logic               we;
        logic [BADDR_W-1:0] waddr;
        logic [BADDR_W-1:0] raddr;
        t_pix               wdata;
        t_weight            wx;
        t_weight            wy;
    } t_lane_ctl;

endpackage
`default_nettype wire

FILE: design/bir_map.sv
`default_nettype none
module bir_map (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [bir_pkg::COORD_W-1:0]  i_coord,
    input  wire logic [bir_pkg::SCALE_W-1:0]  i_scale,
    input  wire logic [bir_pkg::DIM_W-1:0]    i_size,
    output bir_pkg::t_axis_map                o_map
);
    import bir_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [U_W-1:0]     u;
    logic [WHOLE_W-1:0] whole;
    t_axis_map          n_map;
    t_axis_map          r_map;

    // (2d+1) * scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'({i_coord, 1'b1}) * PROD_W'(i_scale);
        end
    end

    // bias, floor and clamp to the source grid
    always_comb begin
        u     = U_W'(r_prod) + POS_HALF;
        whole = u[U_W-1:POS_SHIFT];
        if (whole == '0) begin
            n_map.idx  = '0;
            n_map.frac = '0;
        end else if (whole >= WHOLE_W'(i_size)) begin
            n_map.idx  = IDX_W'(i_size - DIM_W'(2));
            n_map.frac = '0;
        end else begin
            n_map.idx  = IDX_W'(whole - WHOLE_W'(1));
            n_map.frac = u[POS_SHIFT-1 -: FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_map <= n_map;
        end
    end

    assign o_map = r_map;

endmodule
`default_nettype wire

FILE: design/bir_lane.sv
`default_nettype none
module bir_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  bir_pkg::t_lane_ctl i_ctl,
    output bir_pkg::t_lane_prod o_prod
);
    import bir_pkg::*;

    t_pix               r_mem [BANK_DEPTH];
    t_pix               r_rd;
    logic [WPROD_W-1:0] r_wp;
    t_lane_prod         r_prod;

    // bank port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[i_ctl.raddr];
            if (i_ctl.we) begin
                r_mem[i_ctl.waddr] <= i_ctl.wdata;
            end
        end
    end

    // joint weight of this neighbor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wp <= WPROD_W'(i_ctl.wx) * WPROD_W'(i_ctl.wy);
        end
    end

    // weighted channels
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CH_N; k++) begin
                r_prod[k] <= PRODC_W'(r_rd[k]) * PRODC_W'(r_wp);
            end
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

FILE: design/bir_merge.sv
`default_nettype none
module bir_merge (
    input  bir_pkg::t_lane_prod i_prod [bir_pkg::LANES],
    output bir_pkg::t_pix       o_pix
);
    import bir_pkg::*;

    logic [ACC_W-1:0] acc [CH_N];

    // sum the four neighbors and drop the weight scale
    always_comb begin
        for (int k = 0; k < CH_N; k++) begin
            acc[k] = '0;
            for (int l = 0; l < LANES; l++) begin
                acc[k] = acc[k] + ACC_W'(i_prod[l][k]);
            end
            o_pix[k] = acc[k][2*FRAC_BITS +: CH_W];
        end
    end

endmodule
`default_nettype wire

FILE: design/bilinear_image_resize.sv
// Bilinear scaler for packed three-channel pixels.
// Input stream s_axis: tuser selects the action. A load word writes one source
// pixel (col, row, three channels) into a frame store of four banks split by
// row and column parity; a load outside the store is dropped. A request word
// names a destination pixel and yields one output word on m_axis carrying the
// same coordinate and the three interpolated channels. Loads yield nothing.
// Configuration: i_cfg_valid/o_cfg_ready with an index and data; registers are
// source width, source height, scale x, scale y (Q8.16). Write them only while
// no request is in flight. o_cfg_ready is always high.
// Throughput: one word per cycle while s_axis_tready is high, loads and requests
// mixed freely; the four banks give all four neighbors of a request in a single read.
// Stages: a request passes multiply, clamp, bank read, weighting and merge into
// the output register before it shows on m_axis.
// A request must only read pixels loaded before it.
// Stall: when m_axis_tready is low and a result waits, the pipeline keeps
// moving until the next request reaches the last stage; then s_axis_tready drops.
// Reset: pipeline emptied, registers back to 128, 128, 1.0, 1.0. The frame
// store holds no defined content until loaded.
`default_nettype none
module bilinear_image_resize (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bir_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bir_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [47:0]                     s_axis_tdata,  // col, row, ch0, ch1, ch2
    input  wire logic                            s_axis_tuser,  // action
    // result words
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [47:0]                          m_axis_tdata   // col, row, ch0, ch1, ch2
);
    import bir_pkg::*;

    // configuration registers
    logic [DIM_CFG_W-1:0] r_src_w;
    logic [DIM_CFG_W-1:0] r_src_h;
    logic [SCALE_W-1:0]   r_scale_x;
    logic [SCALE_W-1:0]   r_scale_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= DIM_CFG_W'(128);
            r_src_h   <= DIM_CFG_W'(128);
            r_scale_x <= SCALE_W'(65536);
            r_scale_y <= SCALE_W'(65536);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_SRC_HEIGHT: r_src_h   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_SCALE_X:    r_scale_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:    r_scale_y <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // effective dimensions
    logic [DIM_W-1:0] size_x;
    logic [DIM_W-1:0] size_y;

    always_comb begin
        if (r_src_w < DIM_CFG_W'(2)) begin
            size_x = DIM_W'(2);
        end else if (16'(r_src_w) > 16'(MAX_SRC_WIDTH)) begin
            size_x = DIM_W'(MAX_SRC_WIDTH);
        end else begin
            size_x = DIM_W'(r_src_w);
        end
        if (r_src_h < DIM_CFG_W'(2)) begin
            size_y = DIM_W'(2);
        end else if (16'(r_src_h) > 16'(MAX_SRC_HEIGHT)) begin
            size_y = DIM_W'(MAX_SRC_HEIGHT);
        end else begin
            size_y = DIM_W'(r_src_h);
        end
    end

    // pipeline control
    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_req1, r_req2, r_req3, r_req4, r_req5;
    logic r_out_valid;

    assign adv           = !r_out_valid || m_axis_tready || !(r_v5 && r_req5);
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // item payload along the pipeline
    logic [COORD_W-1:0] r_col1, r_col2, r_col3, r_col4, r_col5;
    logic [COORD_W-1:0] r_row1, r_row2, r_row3, r_row4, r_row5;
    t_pix               r_pix1, r_pix2, r_pix3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req1 <= (t_action'(s_axis_tuser) == ACT_REQUEST);
            r_col1 <= s_axis_tdata[11:0];
            r_row1 <= s_axis_tdata[23:12];
            r_pix1 <= s_axis_tdata[47:24];
            r_req2 <= r_req1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_pix2 <= r_pix1;
            r_req3 <= r_req2;
            r_col3 <= r_col2;
            r_row3 <= r_row2;
            r_pix3 <= r_pix2;
            r_req4 <= r_req3;
            r_col4 <= r_col3;
            r_row4 <= r_row3;
            r_req5 <= r_req4;
            r_col5 <= r_col4;
            r_row5 <= r_row4;
        end
    end

    // axis mapping, two stages each
    t_axis_map map_x;
    t_axis_map map_y;

    bir_map u_map_x (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_coord (r_col1),
        .i_scale (r_scale_x),
        .i_size  (size_x),
        .o_map   (map_x)
    );

    bir_map u_map_y (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_coord (r_row1),
        .i_scale (r_scale_y),
        .i_size  (size_y),
        .o_map   (map_y)
    );

    // bank addresses and weights for each lane
    t_lane_ctl          lane_ctl [LANES];
    logic [LANES-1:0]   lane_we;

    always_comb begin
        logic [COL_W-1:0]  sx;
        logic [ROW_W-1:0]  sy;
        logic [COL_W:0]    sx_inc;
        logic [ROW_W:0]    sy_inc;
        logic [BCOL_W-1:0] ch0, ch1, lch;
        logic [BROW_W-1:0] rh0, rh1, lrh;
        t_weight           wx0, wx1, wy0, wy1;
        logic              in_bounds;
        logic              cp, rp;
        sx        = map_x.idx[COL_W-1:0];
        sy        = map_y.idx[ROW_W-1:0];
        sx_inc    = {1'b0, sx} + (COL_W+1)'(1);
        sy_inc    = {1'b0, sy} + (ROW_W+1)'(1);
        // even-parity bank holds (idx+1)/2, odd-parity bank holds idx/2
        ch0       = BCOL_W'(sx_inc >> 1);
        ch1       = BCOL_W'(sx >> 1);
        rh0       = BROW_W'(sy_inc >> 1);
        rh1       = BROW_W'(sy >> 1);
        lch       = BCOL_W'(r_col3 >> 1);
        lrh       = BROW_W'(r_row3 >> 1);
        wx1       = WGT_W'(map_x.frac);
        wx0       = WEIGHT_ONE - wx1;
        wy1       = WGT_W'(map_y.frac);
        wy0       = WEIGHT_ONE - wy1;
        in_bounds = ({1'b0, r_col3} < (COORD_W+1)'(MAX_SRC_WIDTH))
                 && ({1'b0, r_row3} < (COORD_W+1)'(MAX_SRC_HEIGHT));
        for (int l = 0; l < LANES; l++) begin
            cp = 1'(l & 1);
            rp = 1'(l >> 1);
            lane_we[l]        = r_v3 && !r_req3 && in_bounds
                             && (r_col3[0] == cp) && (r_row3[0] == rp);
            lane_ctl[l].we    = adv && lane_we[l];
            lane_ctl[l].waddr = {lrh, lch};
            lane_ctl[l].raddr = {(rp ? rh1 : rh0), (cp ? ch1 : ch0)};
            lane_ctl[l].wdata = r_pix3;
            lane_ctl[l].wx    = (sx[0] == cp) ? wx0 : wx1;
            lane_ctl[l].wy    = (sy[0] == rp) ? wy0 : wy1;
        end
    end

    // one lane per bank
    t_lane_prod lane_prod [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bir_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_ctl  (lane_ctl[g]),
            .o_prod (lane_prod[g])
        );
    end

    // merge and output register
    t_pix               merged;
    t_pix               r_out_pix;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;

    bir_merge u_merge (
        .i_prod (lane_prod),
        .o_pix  (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_v5 && r_req5) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v5 && r_req5) begin
            r_out_pix <= merged;
            r_out_col <= r_col5;
            r_out_row <= r_row5;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pix, r_out_row, r_out_col};

`ifndef SYNTH
    // a result only appears from a request leaving the last lane stage
    a_out_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_v5 && r_req5))
        else $error("result word without a request behind it");

    // a load writes at most the one bank of its parity
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(lane_we))
        else $error("load writes more than one bank");

    // a stalled pipeline holds its contents
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable({r_v1, r_v2, r_v3, r_v4, r_v5}))
        else $error("pipeline moved while stalled");

    // clamped indexes leave room for the second neighbor
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_req3) |->
        ((DIM_W'(map_x.idx) + DIM_W'(2)) <= size_x)
        && ((DIM_W'(map_y.idx) + DIM_W'(2)) <= size_y))
        else $error("source index out of range");
`endif

endmodule
`default_nettype wire
